/* hdl/lbp_pkg.sv */
`timescale 1ns / 1ps
// shared constants, register codes and types of the 3x3 local binary pattern block
package lbp_pkg;

  localparam int LBP_MAX_WIDTH = 1024;  // default line store depth
  localparam int PIX_W         = 8;
  localparam int FW_W          = 11;    // frame_width register width
  localparam int FH_W          = 16;    // frame_height register width
  localparam int ROW_W         = 17;    // row counter, reaches height + 1
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // neighbor weights, row above / center row / row below, left to right
  localparam logic [PIX_W-1:0] LBP_WEIGHT [3][3] = '{
    '{8'd128, 8'd64, 8'd32},
    '{8'd1,   8'd0,  8'd16},
    '{8'd2,   8'd4,  8'd8}
  };

  // per-item control worked out from the raster position
  typedef struct packed {
    logic produce;    // item yields a code
    logic frame_end;  // code of the frame's last pixel
    logic in_frame;   // item position lies inside the frame
    logic top_ok;     // row above the center is in frame
    logic bot_ok;     // row below the center is in frame
    logic left_ok;    // column left of the center is in frame
    logic right_ok;   // column right of the center is in frame
  } lbp_flags_t;

endpackage

/* hdl/lbp_if.sv */
`timescale 1ns / 1ps
// stream interfaces for pixel items and code results
interface lbp_in_if import lbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, mode, pixel, input ready);
  modport sink   (input valid, mode, pixel, output ready);
endinterface

interface lbp_out_if import lbp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] code;
  logic             last_of_run;
  logic             frame_end;

  modport source (output valid, code, last_of_run, frame_end, input ready);
  modport sink   (input valid, code, last_of_run, frame_end, output ready);
endinterface

/* hdl/lbp_pos.sv */
`timescale 1ns / 1ps
// raster position counters and per-item border and output control
module lbp_pos import lbp_pkg::*; #(
  parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         accept,
  input  logic [$clog2(MAX_WIDTH)-1:0] w_last,
  input  logic [FH_W-1:0]              h_eff,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output lbp_flags_t                   flags
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0]    col_count, col_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic [ROW_W-1:0] h_ext, h_m1, cr;
  logic [CW-1:0]    cc;
  logic             have;

  assign h_ext = ROW_W'(h_eff);
  assign h_m1  = h_ext - ROW_W'(1);
  assign col   = col_count;

  always_comb begin
    // the center of this item's code is one row and one pixel back
    if (col_count == '0) begin
      have = row_count >= ROW_W'(2);
      cr   = row_count - ROW_W'(2);
      cc   = w_last;
    end else begin
      have = row_count != '0;
      cr   = row_count - ROW_W'(1);
      cc   = col_count - CW'(1);
    end
    flags.produce   = have && (cr < h_ext);
    flags.frame_end = flags.produce && (cr == h_m1) && (cc == w_last);
    flags.in_frame  = row_count < h_ext;
    flags.top_ok    = cr != '0;
    flags.bot_ok    = cr != h_m1;
    flags.left_ok   = cc != '0;
    flags.right_ok  = cc != w_last;

    if (flags.frame_end) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (col_count == w_last) begin
      col_count_next = '0;
      row_count_next = row_count + ROW_W'(1);
    end else begin
      col_count_next = col_count + CW'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    col_count <= w_last)
    else $error("column counter beyond the row");

  a_row_bounded: assert property (@(posedge clk) disable iff (rst)
    row_count <= h_ext + ROW_W'(1))
    else $error("row counter beyond the drain rows");

endmodule

/* hdl/lbp_lines.sv */
`timescale 1ns / 1ps
// two line stores with registered read and a bypass for same-column back-to-back items
module lbp_lines import lbp_pkg::*; #(
  parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]             wr_val,
  output logic [PIX_W-1:0]             col_two,
  output logic [PIX_W-1:0]             col_above
);

  logic [PIX_W-1:0] mem_two   [MAX_WIDTH];
  logic [PIX_W-1:0] mem_above [MAX_WIDTH];
  logic [PIX_W-1:0] rd_two, rd_above;
  logic [PIX_W-1:0] byp_two, byp_above;
  logic             byp;

  // the older row moves down one store as the new pixel lands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_above[wr_addr] <= wr_val;
      mem_two[wr_addr]   <= col_above;
    end
    if (rd_en) begin
      rd_above <= mem_above[rd_addr];
      rd_two   <= mem_two[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_above <= wr_val;
      byp_two   <= col_above;
    end
  end

  assign col_two   = byp ? byp_two   : rd_two;
  assign col_above = byp ? byp_above : rd_above;

  a_bypass_hit: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en && (wr_addr == rd_addr) |=> byp)
    else $error("same-column read missed the bypass");

endmodule

/* hdl/lbp_window.sv */
`timescale 1ns / 1ps
// 3x3 window columns and the eight neighbor compares
module lbp_window import lbp_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [PIX_W-1:0] col_two,
  input  logic [PIX_W-1:0] col_above,
  input  logic [PIX_W-1:0] col_new,
  input  lbp_flags_t       flags,
  output logic [PIX_W-1:0] code
);

  logic [PIX_W-1:0] win_l [3];  // column left of the center
  logic [PIX_W-1:0] win_c [3];  // center column
  logic [PIX_W-1:0] nb    [3][3];
  logic [PIX_W-1:0] center;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        win_l[i] <= win_c[i];
      end
      win_c[0] <= col_two;
      win_c[1] <= col_above;
      win_c[2] <= col_new;
    end
  end

  // neighbors: the two window columns plus the incoming column on the right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nb[i][0] = win_l[i];
      nb[i][1] = win_c[i];
    end
    nb[0][2] = col_two;
    nb[1][2] = col_above;
    nb[2][2] = col_new;
  end

  assign center = win_c[1];

  always_comb begin
    logic ok;
    code = '0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        ok = !(dy == 1 && dx == 1)
          && (dy != 0 || flags.top_ok)  && (dy != 2 || flags.bot_ok)
          && (dx != 0 || flags.left_ok) && (dx != 2 || flags.right_ok);
        if (ok && (nb[dy][dx] <= center)) begin
          code = code | LBP_WEIGHT[dy][dx];
        end
      end
    end
  end

endmodule

/* hdl/local_binary_pattern_3x3.sv */
`timescale 1ns / 1ps
// top level of the 3x3 local binary pattern stream block
// Takes 8-bit grey pixels in raster order, one transfer per clock, and returns
// one 8-bit local binary pattern code per pixel in raster order. Each code
// leaves one row and one pixel after its pixel enters, so after the last pixel
// of a frame the source sends frame_width + 1 more items (drain items, or any
// items) to push out the rest; frame_end marks the code of the last pixel and
// the block then starts a new frame. The first row and the first pixel of the
// second row produce no result. An item passes the input register and then the
// output register: the line store read is issued at the transfer edge together
// with the input register, and the eight compares land in the output register,
// with the window shift, when stage 1 moves on. A new item is taken every cycle
// unless a finished code waits on a stalled output. last_of_run is always 1.
// Writing frame_width or frame_height restarts the frame; width is clamped to
// 2..MAX_WIDTH and height to at least 2. No clearing pass after reset.
module local_binary_pattern_3x3 import lbp_pkg::*; #(
  parameter int MAX_WIDTH = LBP_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  lbp_in_if.sink                in_ch,
  lbp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;  // width compare width

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_clear;
  logic [EW-1:0]   fw_ext;
  logic [CW-1:0]   w_last;
  logic [FH_W-1:0] h_eff;

  // item position at the input
  logic [CW-1:0]   pos_col;
  lbp_flags_t      pos_flags;

  // stage 1: item waiting on its line store read
  logic             s1_valid;
  logic [CW-1:0]    s1_addr;
  logic [PIX_W-1:0] s1_val;
  lbp_flags_t       s1_flags;
  logic             s1_adv;

  logic             in_xfer;
  logic [PIX_W-1:0] col_two, col_above, code_now;

  // output register
  logic             out_valid;
  logic [PIX_W-1:0] out_code;
  logic             out_end;

  // ---------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // a write to a mapped register starts a new frame
  assign cfg_clear = cfg_we && (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH
                             || cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT);

  // clamp width to 2..MAX_WIDTH, kept as last column index
  assign fw_ext = EW'(frame_width);
  always_comb begin
    if (fw_ext < EW'(2)) begin
      w_last = CW'(1);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(fw_ext - EW'(1));
    end
  end

  assign h_eff = (frame_height < FH_W'(2)) ? FH_W'(2) : frame_height;

  // ---------------------------------------------------------------------
  // handshake: stage 1 moves on unless its code would overwrite a waiting one
  // ---------------------------------------------------------------------
  assign s1_adv      = s1_valid && (!s1_flags.produce || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  lbp_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_clear),
    .accept (in_xfer),
    .w_last (w_last),
    .h_eff  (h_eff),
    .col    (pos_col),
    .flags  (pos_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // positions below the frame feed zero into the line stores
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr  <= pos_col;
      s1_flags <= pos_flags;
      s1_val   <= pos_flags.in_frame ? in_ch.pixel : '0;
    end
  end

  lbp_lines #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_xfer),
    .rd_addr   (pos_col),
    .wr_en     (s1_adv),
    .wr_addr   (s1_addr),
    .wr_val    (s1_val),
    .col_two   (col_two),
    .col_above (col_above)
  );

  lbp_window u_window (
    .clk       (clk),
    .adv       (s1_adv),
    .col_two   (col_two),
    .col_above (col_above),
    .col_new   (s1_val),
    .flags     (s1_flags),
    .code      (code_now)
  );

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_flags.produce) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.produce) begin
      out_code <= code_now;
      out_end  <= s1_flags.frame_end;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.code        = out_code;
  assign out_ch.frame_end   = out_end;
  assign out_ch.last_of_run = 1'b1;

  // frame end only ever rides on an item that yields a code
  a_end_needs_code: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_flags.frame_end |-> s1_flags.produce)
    else $error("frame end on an item without a code");

  // a code moving on never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_flags.produce && out_valid |-> out_ch.ready)
    else $error("waiting code overwritten");

endmodule

/* bench/local_binary_pattern_3x3_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the 3x3 local binary pattern stream block
module local_binary_pattern_3x3_tb;
  import lbp_pkg::*;

  localparam int MAX_W         = LBP_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 8;       // lets the pipeline empty, with margin
  localparam int CYCLE_LIMIT   = 300000;  // far above the slowest correct run
  localparam int MAX_REPORTS   = 100;

  // item kinds on the mode field
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // register indexes past the end of the list, the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // neighbor weights, row above / center row / row below, left to right
  localparam logic [PIX_W-1:0] NEIGHBOR_WEIGHT [3][3] = '{
    '{8'd128, 8'd64, 8'd32},
    '{8'd1,   8'd0,  8'd16},
    '{8'd2,   8'd4,  8'd8}
  };

  typedef struct {
    logic [PIX_W-1:0] code;
    logic             last_of_run;
    logic             frame_end;
    int unsigned      row;   // center position, for mismatch messages
    int unsigned      col;
  } code_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbp_in_if  pix_if ();
  lbp_out_if code_if ();

  local_binary_pattern_3x3 #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (pix_if),
    .out_ch   (code_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state: its own line stores, window, raster position and registers
  logic [PIX_W-1:0] line_two_up [MAX_W];
  logic [PIX_W-1:0] line_up [MAX_W];
  logic [PIX_W-1:0] lbp_win [3][3];
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  code_result_t expected_codes[$];
  code_result_t oldest;

  // idling knobs, percent of cycles
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;   // long output hold-off, counted down by the receiver

  int error_count        = 0;
  int cycle_count        = 0;
  int items_sent         = 0;
  int codes_checked      = 0;
  int frames_closed      = 0;
  int input_stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // works out the code this item releases, if any, and advances the raster position
  function automatic void predict_code(input logic [PIX_W-1:0] pix);
    int unsigned      w, h, c, r, cc, cr;
    int               dy, dx;
    bit               have;
    logic [PIX_W-1:0] val, acc;
    code_result_t     res;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < 2) ? 2 : height_reg;
    c = col_pos;
    r = row_pos;
    // drain positions load zero whatever the item carries
    val = (r < h) ? pix : '0;
    for (dy = 0; dy < 3; dy++) begin
      lbp_win[dy][0] = lbp_win[dy][1];
      lbp_win[dy][1] = lbp_win[dy][2];
    end
    lbp_win[0][2] = line_two_up[c];
    lbp_win[1][2] = line_up[c];
    lbp_win[2][2] = val;
    line_two_up[c] = line_up[c];
    line_up[c] = val;
    // center sits one row and one pixel behind this item
    if (c == 0) begin
      have = (r >= 2);
      cr = r - 2;
      cc = w - 1;
    end else begin
      have = (r >= 1);
      cr = r - 1;
      cc = c - 1;
    end
    if (have && cr < h) begin
      acc = '0;
      // store entries never written only ever land on neighbors outside the frame
      for (dy = 0; dy < 3; dy++)
        for (dx = 0; dx < 3; dx++)
          if (!(dy == 1 && dx == 1) && !(dy == 0 && cr == 0) && !(dy == 2 && cr + 1 >= h) &&
              !(dx == 0 && cc == 0) && !(dx == 2 && cc + 1 >= w) &&
              lbp_win[dy][dx] <= lbp_win[1][1])
            acc += NEIGHBOR_WEIGHT[dy][dx];
      res.code = acc;
      res.last_of_run = 1'b1;
      res.frame_end = (cr == h - 1 && cc == w - 1);
      res.row = cr;
      res.col = cc;
      expected_codes.push_back(res);
      if (res.frame_end) begin
        // last pixel out, next item is pixel zero of a new frame
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r > h + 1) begin
      r = 0;
      c = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // one process watches every transfer: results checked first, then the
  // accepted pixel predicted, then any register write applied
  always @(posedge clk) begin
    if (rst) begin
      lbp_win = '{default: '0};
      col_pos = 0;
      row_pos = 0;
      width_reg = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
    end else begin
      if (code_if.valid && code_if.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("code %0d with nothing expected", code_if.code));
        end else begin
          oldest = expected_codes.pop_front();
          codes_checked++;
          if (code_if.code !== oldest.code)
            report_mismatch($sformatf("pixel (%0d,%0d) code %0d, expected %0d",
                                      oldest.row, oldest.col, code_if.code, oldest.code));
          if (code_if.last_of_run !== oldest.last_of_run)
            report_mismatch($sformatf("pixel (%0d,%0d) last_of_run %b, expected %b",
                                      oldest.row, oldest.col, code_if.last_of_run,
                                      oldest.last_of_run));
          if (code_if.frame_end !== oldest.frame_end)
            report_mismatch($sformatf("pixel (%0d,%0d) frame_end %b, expected %b",
                                      oldest.row, oldest.col, code_if.frame_end,
                                      oldest.frame_end));
          if (oldest.frame_end) frames_closed++;
        end
      end
      if (pix_if.valid && pix_if.ready) predict_code(pix_if.pixel);
      if (pix_if.valid && !pix_if.ready) input_stall_cycles++;
      if (cfg_we) begin
        // a write to a listed register restarts the frame
        unique case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data[FW_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data[FH_W-1:0];
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
    end
  end

  // receiver: random stalls, or a long hold-off when a test asks for one
  initial begin
    code_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        code_if.ready <= 1'b0;
      end else begin
        code_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes still outstanding", cycle_count,
               expected_codes.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one item over the pixel channel, with random idle cycles ahead of it
  task automatic send_item(input logic m, input logic [PIX_W-1:0] p);
    while ($urandom_range(99) < src_gap_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.mode  <= m;
    pix_if.pixel <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // write one register, then drop the write strobe before the next so writes never merge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, wait for every expected code, then let the pipe empty
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(2));         // flat dark patch, lots of ties
      1:       return 8'(253 + $urandom_range(2));   // flat bright patch
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // raster positions first .. first+count-1 of a w x h frame; mode is mostly
  // right for the position, sometimes flipped since the position alone decides
  task automatic send_run(input int first, input int count, input int w, input int h);
    int pos;
    for (pos = first; pos < first + count; pos++) begin
      if (pos < w * h)
        send_item(($urandom_range(9) == 0) ? MODE_DRAIN : MODE_PIXEL, rand_pixel());
      else
        send_item(($urandom_range(9) == 0) ? MODE_PIXEL : MODE_DRAIN, 8'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(input int w, input int h);
    send_run(0, w * h + w + 1, w, h);
  endtask

  // registers straight out of reset: 640 wide, so a short run releases no code
  task automatic test_reset_values();
    send_run(0, 40, 640, 480);
    settle();
  endtask

  // extreme values, ties with the center, both item kinds in and beyond the frame
  task automatic test_directed_extremes();
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    send_item(MODE_PIXEL, 8'd255);
    send_item(MODE_PIXEL, 8'd0);
    send_item(MODE_PIXEL, 8'd128);
    send_item(MODE_PIXEL, 8'd128);
    send_item(MODE_DRAIN, 8'd128);   // drain inside the frame counts as a pixel
    send_item(MODE_PIXEL, 8'd129);
    send_item(MODE_PIXEL, 8'd0);
    send_item(MODE_PIXEL, 8'd127);
    send_item(MODE_PIXEL, 8'd255);
    send_item(MODE_DRAIN, 8'hFF);
    send_item(MODE_PIXEL, 8'hAA);    // pixel beyond the frame counts as a drain
    send_item(MODE_DRAIN, 8'h00);
    send_item(MODE_PIXEL, 8'h55);
    settle();
    // smallest frame, all equal so every in-frame neighbor sets its bit
    write_reg(REG_FRAME_WIDTH, 16'd2);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    repeat (4) send_item(MODE_PIXEL, 8'd0);
    send_item(MODE_PIXEL, 8'hFF);
    send_item(MODE_PIXEL, 8'h01);
    send_item(MODE_DRAIN, 8'h80);
    settle();
  endtask

  // out-of-range values, unused upper bits, tallest frame, ignored indexes
  task automatic test_register_clamps();
    write_reg(REG_FRAME_WIDTH, 16'd0);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    send_frame(2, 2);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'd1);
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    send_frame(2, 2);
    settle();
    // only the low 11 bits of the width count, so this is 3 wide
    write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
    write_reg(REG_FRAME_WIDTH, 16'hF803);
    send_run(0, 13, 3, 65535);
    settle();
    // writes to spare indexes must not restart the frame half way through
    write_reg(REG_FRAME_WIDTH, 16'd4);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    send_run(0, 6, 4, 3);
    settle();
    write_reg(REG_SPARE_2, 16'($urandom));
    write_reg(REG_SPARE_3, 16'($urandom));
    send_run(6, 4 * 3 + 5 - 6, 4, 3);
    settle();
  endtask

  // mostly whole frames of random content, back to back, now and then one
  // abandoned half way and restarted by the next register write
  task automatic test_random_frames(input int budget);
    int                    first, w, h;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(2, 4);
      end else begin
        w = $urandom_range(2, 8);
        h = $urandom_range(2, 6);
      end
      // junk in the unused width bits, and 0 or 1 now and then for a 2
      wdata = {5'($urandom), 11'(w)};
      if (w == 2 && $urandom_range(1) == 1) wdata[FW_W-1:0] = 11'($urandom_range(1));
      hdata = 16'(h);
      if (h == 2 && $urandom_range(1) == 1) hdata = 16'($urandom_range(1));
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, hdata);
      repeat ($urandom_range(1, 3)) send_frame(w, h);
      if ($urandom_range(4) == 0) send_run(0, $urandom_range(1, w * h), w, h);
      settle();
    end
  endtask

  // receiver holds off for a long stretch while pixels keep coming
  task automatic test_output_backpressure();
    write_reg(REG_FRAME_WIDTH, 16'd8);
    write_reg(REG_FRAME_HEIGHT, 16'd6);
    hold_left = 300;
    send_frame(8, 6);
    settle();
  endtask

  // widest row, written exactly and as an all-ones value that clamps; a short
  // run stays inside row zero, so no code may come out
  task automatic test_wide_frames();
    write_reg(REG_FRAME_WIDTH, 16'd1024);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    send_run(0, 20, 1024, 2);
    settle();
    write_reg(REG_FRAME_WIDTH, 16'hFFFF);
    send_run(0, 20, 1024, 2);
    settle();
  endtask

  initial begin
    rst          <= 1'b1;
    pix_if.valid <= 1'b0;
    pix_if.mode  <= MODE_PIXEL;
    pix_if.pixel <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_FRAME_WIDTH;
    cfg_data     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles a third of the time, receiver most of the time
    src_gap_pct = 34;
    sink_stall_pct = 83;
    test_reset_values();
    test_directed_extremes();
    test_register_clamps();
    test_random_frames(80);

    // roles swapped
    src_gap_pct = 83;
    sink_stall_pct = 34;
    test_random_frames(80);

    // full rate both sides
    src_gap_pct = 0;
    sink_stall_pct = 0;
    test_output_backpressure();
    test_wide_frames();
    test_random_frames(80);

    $display("sent %0d pixel and drain items over %0d cycles, %0d frames closed",
             items_sent, cycle_count, frames_closed);
    $display("checked %0d codes, input held off for %0d cycles, %0d mismatches",
             codes_checked, input_stall_cycles, error_count);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
